// File: sv/mrf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mrf_pkg
// Shared types, constants and fixed-point helpers for the multipole rotator.
// ---------------------------------------------------------------------------
package mrf_pkg;

  localparam int MAX_DEGREES = 8;
  localparam int MOMENT_BITS = 32;
  localparam int COEFF_BITS  = 32;
  localparam int COEFF_FRAC  = COEFF_BITS - 2;
  localparam int ORD_MAX     = 2 * MAX_DEGREES - 1;
  localparam int NCELLS      = ORD_MAX;
  localparam int DEG_W       = $clog2(MAX_DEGREES);
  localparam int ORD_W       = $clog2(ORD_MAX + 1);
  localparam int DC_W        = 4;
  localparam int MOM_DEPTH   = MAX_DEGREES * MAX_DEGREES;
  localparam int MOM_AW      = $clog2(MOM_DEPTH);
  localparam int MAT_DEPTH   = MAX_DEGREES * ORD_MAX * ORD_MAX;
  localparam int MAT_AW      = $clog2(MAT_DEPTH);
  localparam int MATB_AW     = $clog2(MAX_DEGREES * ORD_MAX);
  localparam int PH_AW       = $clog2(MAX_DEGREES);
  localparam int PROD_W      = MOMENT_BITS + COEFF_BITS;
  localparam int ACC_W       = PROD_W + 6;

  typedef enum logic [1:0] {
    OP_LOAD_MOM = 2'd0,
    OP_LOAD_PH  = 2'd1,
    OP_LOAD_MAT = 2'd2,
    OP_RUN      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ZRD, ST_ZMUL, ST_ZWR, ST_MAC, ST_FIN, ST_EMIT
  } state_t;

  // control broadcast from sequencer to the cell row
  typedef struct packed {
    logic clear;   // zero accumulators
    logic mac;     // accumulate this column
    logic shift;   // shift result chain toward cell 0
    logic load;    // capture finished sums into the result chain
  } cell_ctl_t;

  function automatic logic signed [MOMENT_BITS-1:0] finish(
      input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-1:0] lim_hi;
    logic signed [ACC_W-1:0] lim_lo;
    lim_hi = (ACC_W)'((64'sd1 <<< (MOMENT_BITS - 1)) - 64'sd1);
    lim_lo = -(ACC_W)'(64'sd1 <<< (MOMENT_BITS - 1));
    s = (v + (ACC_W)'(64'sd1 <<< (COEFF_FRAC - 1))) >>> COEFF_FRAC;
    if (s > lim_hi) finish = lim_hi[MOMENT_BITS-1:0];
    else if (s < lim_lo) finish = lim_lo[MOMENT_BITS-1:0];
    else finish = s[MOMENT_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/mrf_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mrf_cell
// One output row: accumulates w * z for its own row, then holds the rounded
// result in a shift chain toward the output.
// ---------------------------------------------------------------------------
module mrf_cell
  import mrf_pkg::*;
(
  input  wire logic                          clk,
  input  wire cell_ctl_t                     ctl,
  input  wire logic                          en,      // cell row in use
  input  wire logic signed [COEFF_BITS-1:0]  w,
  input  wire logic signed [MOMENT_BITS-1:0] z_re,
  input  wire logic signed [MOMENT_BITS-1:0] z_im,
  input  wire logic signed [MOMENT_BITS-1:0] nb_re,   // from neighbor above
  input  wire logic signed [MOMENT_BITS-1:0] nb_im,
  output logic signed [MOMENT_BITS-1:0]      q_re,
  output logic signed [MOMENT_BITS-1:0]      q_im
);

  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic signed [MOMENT_BITS-1:0] q_re_r, q_im_r;
  logic signed [PROD_W-1:0] pre, pim;

  assign pre = PROD_W'(w) * PROD_W'(z_re);
  assign pim = PROD_W'(w) * PROD_W'(z_im);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (ctl.mac && en) begin
      acc_re_r <= acc_re_r + ACC_W'(pre);
      acc_im_r <= acc_im_r + ACC_W'(pim);
    end
    if (ctl.load) begin
      q_re_r <= finish(acc_re_r);
      q_im_r <= finish(acc_im_r);
    end else if (ctl.shift) begin
      q_re_r <= nb_re;
      q_im_r <= nb_im;
    end
  end

  assign q_re = q_re_r;
  assign q_im = q_im_r;

endmodule
`default_nettype wire

// File: sv/mrf_seq.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mrf_seq
// Stores, z-rotation unit and run sequencer. For each degree it z-rotates the
// moments, then streams columns: every cell c gets matrix row r(c) and the
// z-rotated moment at column (c<=p ? j : n-1-j).
// ---------------------------------------------------------------------------
module mrf_seq
  import mrf_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    op,
  input  wire logic [2:0]                    deg,
  input  wire logic [3:0]                    row,
  input  wire logic [3:0]                    col,
  input  wire logic signed [31:0]            v_re,
  input  wire logic signed [31:0]            v_im,
  input  wire logic [DC_W-1:0]               dc,
  output cell_ctl_t                          ctl,
  output logic [NCELLS-1:0]                  cen,
  output logic signed [COEFF_BITS-1:0]       w  [NCELLS],
  output logic signed [MOMENT_BITS-1:0]      zh_re,
  output logic signed [MOMENT_BITS-1:0]      zh_im,
  output logic signed [MOMENT_BITS-1:0]      zl_re,
  output logic signed [MOMENT_BITS-1:0]      zl_im,
  output logic                               ovalid,
  input  wire logic                          oready,
  output logic [DEG_W-1:0]                   odeg,
  output logic [ORD_W-1:0]                   oord,
  output logic                               olast
);

  logic [2*MOMENT_BITS-1:0] mom_mem [MOM_DEPTH];
  logic [2*MOMENT_BITS-1:0] zr_mem  [MOM_DEPTH];
  logic [2*COEFF_BITS-1:0]  ph_mem  [MAX_DEGREES];
  // one matrix bank per cell (row), so every cell reads in the same cycle
  logic [COEFF_BITS-1:0]    mat_mem [NCELLS][MAX_DEGREES*ORD_MAX];

  state_t st_r, st_nxt;
  logic [DEG_W-1:0] p_r, p_nxt;
  logic [ORD_W-1:0] j_r, j_nxt;
  logic [DEG_W:0]   dce;
  logic [ORD_W-1:0] n_m1;
  logic [MOM_AW-1:0] base;

  logic [2*MOMENT_BITS-1:0] mrd_r;
  logic [2*COEFF_BITS-1:0]  prd_r;
  logic [2*MOMENT_BITS-1:0] zh_r, zl_r;
  logic signed [PROD_W-1:0] ac_r, bd_r, ad_r, bc_r;
  logic [ORD_W-1:0] jd_r;

  always_comb begin
    if (dc == '0) dce = (DEG_W+1)'(1);
    else if (dc > DC_W'(MAX_DEGREES)) dce = (DEG_W+1)'(MAX_DEGREES);
    else dce = (DEG_W+1)'(dc);
  end
  assign n_m1 = ORD_W'({p_r, 1'b0});
  assign base = MOM_AW'(p_r) * MOM_AW'(p_r);
  assign in_ready = (st_r == ST_IDLE);

  // loads
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      if (op == OP_LOAD_MOM && 4'(row) <= 4'({deg, 1'b0}))
        mom_mem[MOM_AW'(deg) * MOM_AW'(deg) + MOM_AW'(row)] <= {v_im, v_re};
      if (op == OP_LOAD_PH && row < 4'(MAX_DEGREES - 1))
        ph_mem[row[PH_AW-1:0]] <= {v_im, v_re};
    end
  end

  for (genvar c = 0; c < NCELLS; c++) begin : g_mat
    always_ff @(posedge clk) begin
      if (in_valid && in_ready && op == OP_LOAD_MAT && row == 4'(c) &&
          4'(row) <= 4'({deg, 1'b0}) && col <= 4'({deg, 1'b0}))
        mat_mem[c][MATB_AW'(deg) * MATB_AW'(ORD_MAX) + MATB_AW'(col)] <= v_re;
      w[c] <= mat_mem[c][MATB_AW'(p_r) * MATB_AW'(ORD_MAX) + MATB_AW'(j_r)];
    end
    // cell c computes row c for c<=p, row 2p-c (reversed columns) above
    assign cen[c] = (c <= 2 * p_r);
  end

  // z-rotation datapath
  logic [ORD_W-1:0] pidx;
  logic signed [COEFF_BITS-1:0] px, pyr;
  // one bit wider so the conjugate of the most negative entry stays exact
  logic signed [COEFF_BITS:0] py;
  logic signed [MOMENT_BITS-1:0] ma, mb;
  always_comb begin
    if (j_r < ORD_W'(p_r)) pidx = ORD_W'(p_r) - j_r - ORD_W'(1);
    else pidx = j_r - ORD_W'(p_r) - ORD_W'(1);
  end
  assign ma = mrd_r[MOMENT_BITS-1:0];
  assign mb = mrd_r[2*MOMENT_BITS-1:MOMENT_BITS];
  assign px = prd_r[COEFF_BITS-1:0];
  assign pyr = prd_r[2*COEFF_BITS-1:COEFF_BITS];
  assign py = (jd_r < ORD_W'(p_r)) ? -((COEFF_BITS+1)'(pyr))
                                   :  (COEFF_BITS+1)'(pyr);

  always_ff @(posedge clk) begin
    if (st_r == ST_ZRD) begin
      mrd_r <= mom_mem[base + MOM_AW'(j_r)];
      prd_r <= ph_mem[pidx[PH_AW-1:0]];
      jd_r  <= j_r;
    end
    if (st_r == ST_ZMUL) begin
      ac_r <= PROD_W'(ma) * PROD_W'(px);
      bd_r <= PROD_W'(mb) * PROD_W'(py);
      ad_r <= PROD_W'(ma) * PROD_W'(py);
      bc_r <= PROD_W'(mb) * PROD_W'(px);
    end
    if (st_r == ST_ZWR) begin
      if (jd_r == ORD_W'(p_r)) zr_mem[base + MOM_AW'(jd_r)] <= mrd_r;
      else zr_mem[base + MOM_AW'(jd_r)] <=
        {finish(ACC_W'(ad_r) + ACC_W'(bc_r)), finish(ACC_W'(ac_r) - ACC_W'(bd_r))};
    end
    zh_r <= zr_mem[base + MOM_AW'(j_r)];
    zl_r <= zr_mem[base + MOM_AW'(n_m1 - j_r)];
  end
  assign zh_re = zh_r[MOMENT_BITS-1:0];
  assign zh_im = zh_r[2*MOMENT_BITS-1:MOMENT_BITS];
  assign zl_re = zl_r[MOMENT_BITS-1:0];
  assign zl_im = zl_r[2*MOMENT_BITS-1:MOMENT_BITS];

  // MAC pipeline: address at j, data registered and valid in the next cycle
  logic mac_d_r, mac_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      p_r  <= '0;
      j_r  <= '0;
      mac_d_r  <= 1'b0;
      mac_d2_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      p_r  <= p_nxt;
      j_r  <= j_nxt;
      mac_d_r  <= (st_r == ST_MAC);
      mac_d2_r <= mac_d_r;
    end
  end

  always_comb begin
    st_nxt = st_r;
    p_nxt  = p_r;
    j_nxt  = j_r;
    ctl    = '0;
    ovalid = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid && op == OP_RUN) begin
          st_nxt = ST_ZRD;
          p_nxt  = '0;
          j_nxt  = '0;
        end
      end
      ST_ZRD:  st_nxt = ST_ZMUL;
      ST_ZMUL: st_nxt = ST_ZWR;
      ST_ZWR: begin
        if (j_r == n_m1) begin
          st_nxt = ST_MAC;
          j_nxt  = '0;
          ctl.clear = 1'b1;
        end else begin
          st_nxt = ST_ZRD;
          j_nxt  = j_r + ORD_W'(1);
        end
      end
      ST_MAC: begin
        if (j_r == n_m1) st_nxt = ST_FIN;
        else j_nxt = j_r + ORD_W'(1);
      end
      ST_FIN: begin
        if (!mac_d_r && !mac_d2_r) begin
          ctl.load = 1'b1;
          st_nxt = ST_EMIT;
          j_nxt  = '0;
        end
      end
      ST_EMIT: begin
        ovalid = 1'b1;
        if (oready) begin
          ctl.shift = 1'b1;
          if (j_r == n_m1) begin
            j_nxt = '0;
            if ((DEG_W+1)'(p_r) + (DEG_W+1)'(1) == dce) st_nxt = ST_IDLE;
            else begin
              p_nxt  = p_r + DEG_W'(1);
              st_nxt = ST_ZRD;
            end
          end else j_nxt = j_r + ORD_W'(1);
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    ctl.mac = mac_d_r;
  end

  assign odeg  = p_r;
  assign oord  = j_r;
  assign olast = (j_r == n_m1) && ((DEG_W+1)'(p_r) + (DEG_W+1)'(1) == dce);

  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(ovalid && in_ready)) else $error("output while idle");
  a_no_load_mac: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.load && ctl.mac)) else $error("load during accumulate");
  a_ord_range: assert property (@(posedge clk) disable iff (!rst_n)
    !(ovalid && j_r > n_m1)) else $error("order beyond degree");

endmodule
`default_nettype wire

// File: sv/multipole_rotate_forward.sv
`default_nettype none
// ---------------------------------------------------------------------------
// multipole_rotate_forward
// Rotates complex spherical-harmonic moments (z-phase then Wigner-d).
// ---------------------------------------------------------------------------
// Input words: opcode load moment / phase / matrix write one store entry.
// A run word is taken; the block rotates degrees 0..degree_count-1 (count
// clamped to 1..8). Per degree p (n = 2p+1): z-rotation through one complex
// multiplier (read, multiply, write each), column streaming into a row of n
// cells that each accumulate one output row (cells above p use reversed
// columns), then n output words shifted out of the cell chain. in_tready is
// low during a run. The receiver may stall at any time; the cell chain holds
// its value. out_tlast marks the final word of a run. Reset clears control
// state and sets degree_count to 1; stores are undefined until loaded.
// ---------------------------------------------------------------------------
module multipole_rotate_forward
  import mrf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // opcode[1:0] degree[4:2] row_index[8:5] col_index[12:9]
  // value_re[44:13] value_im[76:45]
  input  wire logic [79:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_degree[2:0] out_order[6:3] result_re[38:7] result_im[70:39]
  output logic [71:0]      out_tdata,
  output logic             out_tlast
);

  logic [DC_W-1:0] dc_r;
  cell_ctl_t ctl;
  logic [NCELLS-1:0] cen;
  logic signed [COEFF_BITS-1:0] w [NCELLS];
  logic signed [MOMENT_BITS-1:0] zh_re, zh_im, zl_re, zl_im;
  logic signed [MOMENT_BITS-1:0] q_re [NCELLS+1];
  logic signed [MOMENT_BITS-1:0] q_im [NCELLS+1];
  logic [DEG_W-1:0] odeg;
  logic [ORD_W-1:0] oord;
  logic [DEG_W-1:0] pd;

  always_ff @(posedge clk) begin
    if (!rst_n) dc_r <= DC_W'(1);
    else if (cfg_we) dc_r <= cfg_wdata;
  end

  mrf_seq u_seq (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .op(in_tdata[1:0]), .deg(in_tdata[4:2]), .row(in_tdata[8:5]),
    .col(in_tdata[12:9]), .v_re(in_tdata[44:13]), .v_im(in_tdata[76:45]),
    .dc(dc_r), .ctl, .cen, .w,
    .zh_re, .zh_im, .zl_re, .zl_im,
    .ovalid(out_tvalid), .oready(out_tready),
    .odeg, .oord, .olast(out_tlast)
  );

  assign pd = odeg;
  assign q_re[NCELLS] = '0;
  assign q_im[NCELLS] = '0;

  // cell c holds output order c; chain shifts toward cell 0
  for (genvar c = 0; c < NCELLS; c++) begin : g_cell
    logic hi;
    assign hi = (c <= pd);
    mrf_cell u_cell (
      .clk, .ctl, .en(cen[c]), .w(w[hi ? c : 2 * pd - c]),
      .z_re(hi ? zh_re : zl_re), .z_im(hi ? zh_im : zl_im),
      .nb_re(q_re[c+1]), .nb_im(q_im[c+1]),
      .q_re(q_re[c]), .q_im(q_im[c])
    );
  end

  assign out_tdata = {1'b0, q_im[0], q_re[0], oord, odeg};

endmodule
`default_nettype wire
